// File: rtl/core/ibd_pkg.sv
package ibd_pkg;

    localparam int MAX_WIDTH    = 4096;
    localparam int MAX_FACTOR   = 16;
    localparam int MAX_CHANNELS = 3;

    localparam int SAMPLE_W  = 8;
    localparam int CHAN_W    = 2;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;

    localparam int POS_W    = $clog2(MAX_WIDTH);
    localparam int SIZE_W   = POS_W + 1;
    localparam int PHASE_W  = $clog2(MAX_FACTOR);
    localparam int FACTOR_W = 5;

    localparam int SUM_W       = 17;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_CHANNELS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    localparam int GAUSS_FACTOR = 3;
    localparam int GAUSS_SHIFT  = 4;

    localparam int RECIP_W     = 25;
    localparam int RECIP_SHIFT = 24;
    localparam int DIV_W       = 9;

    localparam int OUT_DEPTH = 8;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = OUT_PTR_W + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_FACTOR = 2'd2,
        CFG_COLOR  = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] pixel_value;
        logic [CHAN_W-1:0]   channel_index;
        logic                frame_last;
    } result_t;

    // floor(2^24 / (f*f)) for the block divisor
    function automatic logic [RECIP_W-1:0] recip(input logic [FACTOR_W-1:0] f);
        logic [RECIP_W-1:0] r;
        case (f)
            5'd1:    r = 25'd16777216;
            5'd2:    r = 25'd4194304;
            5'd3:    r = 25'd1864135;
            5'd4:    r = 25'd1048576;
            5'd5:    r = 25'd671088;
            5'd6:    r = 25'd466033;
            5'd7:    r = 25'd342392;
            5'd8:    r = 25'd262144;
            5'd9:    r = 25'd207126;
            5'd10:   r = 25'd167772;
            5'd11:   r = 25'd138654;
            5'd12:   r = 25'd116508;
            5'd13:   r = 25'd99273;
            5'd14:   r = 25'd85598;
            5'd15:   r = 25'd74565;
            5'd16:   r = 25'd65536;
            default: r = 25'd16777216;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/core/ibd_in_if.sv
interface ibd_in_if
    import ibd_pkg::*;
    ;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

// File: rtl/core/ibd_out_if.sv
interface ibd_out_if
    import ibd_pkg::*;
    ;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] pixel_value;
    logic [CHAN_W-1:0]   channel_index;
    logic                frame_last;

    modport source (output valid, output pixel_value, output channel_index,
                    output frame_last, input ready);
    modport sink   (input valid, input pixel_value, input channel_index,
                    input frame_last, output ready);
endinterface

// File: rtl/core/ibd_ram.sv
module ibd_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 12288
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= store_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/image_block_downscaler.sv
// Channel   Dir  Payload                                    Accepted when
// samples   in   sample                                     valid && ready
// results   out  pixel_value, channel_index, frame_last     valid && ready
// cfg       in   cfg_index, cfg_data                        cfg_we
//
// One sample per cycle sustained while results does not stall; the column-sum
// store does one read and one write per cycle, with a one-entry bypass for back-to-back hits.
// The sample that completes a block passes s1, s2 and s3, then enters the output queue as a result.
// samples.ready drops only when the 8-entry output queue plus in-flight
// results is full, i.e. when results stalls.
// Reset clears counters and queue at once; the store needs no clearing pass.
// Any register write restarts the frame.
module image_block_downscaler
    import ibd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    ibd_in_if.sink               samples,
    ibd_out_if.source            results
);

    // configuration
    logic [SIZE_W-1:0]   width_reg, height_reg;
    logic [FACTOR_W-1:0] factor_reg;
    logic                color_reg;

    logic [SIZE_W-1:0]   w_eff, h_eff;
    logic [FACTOR_W-1:0] f_eff, f_m1;
    logic [CHAN_W-1:0]   chans, chans_m1;
    logic                gauss;
    logic [DIV_W-1:0]    divisor;

    always_comb
    begin
        if (width_reg == '0)
            w_eff = SIZE_W'(1);
        else if (width_reg > SIZE_W'(MAX_WIDTH))
            w_eff = SIZE_W'(MAX_WIDTH);
        else
            w_eff = width_reg;
        if (height_reg == '0)
            h_eff = SIZE_W'(1);
        else if (height_reg > SIZE_W'(MAX_WIDTH))
            h_eff = SIZE_W'(MAX_WIDTH);
        else
            h_eff = height_reg;
        if (factor_reg == '0)
            f_eff = FACTOR_W'(1);
        else if (factor_reg > FACTOR_W'(MAX_FACTOR))
            f_eff = FACTOR_W'(MAX_FACTOR);
        else
            f_eff = factor_reg;
        chans = color_reg ? CHAN_W'(MAX_CHANNELS) : CHAN_W'(1);
    end

    assign f_m1     = f_eff - FACTOR_W'(1);
    assign chans_m1 = chans - CHAN_W'(1);
    assign gauss    = (f_eff == FACTOR_W'(GAUSS_FACTOR));
    assign divisor  = DIV_W'(f_eff) * DIV_W'(f_eff);

    // position counters
    logic [POS_W-1:0]   col_reg, row_reg, cstart_reg, rstart_reg;
    logic [POS_W-1:0]   col_next, row_next, cstart_next, rstart_next;
    logic [CHAN_W-1:0]  ch_reg, ch_next;
    logic [PHASE_W-1:0] pa_reg, pa_next, pd_reg, pd_next;
    logic [ADDR_W-1:0]  base_reg, base_next;

    logic               bad;
    logic [POS_W-1:0]   cur_col, cur_row, cur_cstart, cur_rstart;
    logic [CHAN_W-1:0]  cur_ch;
    logic [PHASE_W-1:0] cur_pa, cur_pd;
    logic [ADDR_W-1:0]  cur_base;

    assign bad = ({1'b0, col_reg} >= w_eff) || ({1'b0, row_reg} >= h_eff)
              || (ch_reg >= chans) || ({1'b0, pa_reg} >= f_eff)
              || ({1'b0, pd_reg} >= f_eff);

    assign cur_col    = bad ? '0 : col_reg;
    assign cur_row    = bad ? '0 : row_reg;
    assign cur_cstart = bad ? '0 : cstart_reg;
    assign cur_rstart = bad ? '0 : rstart_reg;
    assign cur_ch     = bad ? '0 : ch_reg;
    assign cur_pa     = bad ? '0 : pa_reg;
    assign cur_pd     = bad ? '0 : pd_reg;
    assign cur_base   = bad ? '0 : base_reg;

    // block tests on the current sample
    logic [SIZE_W:0] cs_ext, rs_ext, f_ext, w_ext, h_ext;
    logic            col_ok, row_ok, col_last, row_last;
    logic            active, emit, fresh, last;
    logic [1:0]      shift_amt;
    logic [ADDR_W-1:0] idx;

    assign cs_ext = (SIZE_W+1)'(cur_cstart);
    assign rs_ext = (SIZE_W+1)'(cur_rstart);
    assign f_ext  = (SIZE_W+1)'(f_eff);
    assign w_ext  = (SIZE_W+1)'(w_eff);
    assign h_ext  = (SIZE_W+1)'(h_eff);

    assign col_ok   = (cs_ext + f_ext) <= w_ext;
    assign row_ok   = (rs_ext + f_ext) <= h_ext;
    assign col_last = (cs_ext + (f_ext << 1)) > w_ext;
    assign row_last = (rs_ext + (f_ext << 1)) > h_ext;

    assign active = col_ok && row_ok;
    assign emit   = active && ({1'b0, cur_pa} == f_m1) && ({1'b0, cur_pd} == f_m1);
    assign fresh  = (cur_pa == '0) && (cur_pd == '0);
    assign last   = row_last && col_last && (cur_ch == chans_m1);
    assign idx    = cur_base + ADDR_W'(cur_ch);

    // Gaussian weight 1, 2 or 4 as a shift
    assign shift_amt = gauss ? (2'((cur_pa == PHASE_W'(1))) + 2'((cur_pd == PHASE_W'(1))))
                             : 2'd0;

    // pipeline and output queue state
    logic                s1_valid_reg, s1_emit_reg, s1_fresh_reg, s1_last_reg, s1_fwd_reg;
    logic [ADDR_W-1:0]   s1_idx_reg;
    logic [SAMPLE_W-1:0] s1_x_reg;
    logic [1:0]          s1_sh_reg;
    logic [CHAN_W-1:0]   s1_ch_reg;

    logic                s2_valid_reg, s2_last_reg;
    logic [SUM_W-1:0]    s2_acc_reg;
    logic [CHAN_W-1:0]   s2_ch_reg;

    logic                s3_valid_reg, s3_last_reg;
    logic [SUM_W-1:0]    s3_acc_reg, s3_q0_reg;
    logic [CHAN_W-1:0]   s3_ch_reg;

    result_t              queue_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [OUT_CNT_W-1:0] count_reg;

    logic accept, pop, push;
    logic [OUT_CNT_W:0] pending;

    assign pending = (OUT_CNT_W+1)'(count_reg) + (OUT_CNT_W+1)'(s1_valid_reg && s1_emit_reg)
                   + (OUT_CNT_W+1)'(s2_valid_reg) + (OUT_CNT_W+1)'(s3_valid_reg);

    assign samples.ready = pending < (OUT_CNT_W+1)'(OUT_DEPTH);
    assign accept        = samples.valid && samples.ready;

    // next position
    logic [CHAN_W-1:0]  ch1;
    logic [PHASE_W:0]   pa1, pd1;
    logic [POS_W:0]     col1, row1;

    always_comb
    begin
        ch1  = cur_ch + CHAN_W'(1);
        pa1  = {1'b0, cur_pa} + (PHASE_W+1)'(1);
        pd1  = {1'b0, cur_pd} + (PHASE_W+1)'(1);
        col1 = {1'b0, cur_col} + (POS_W+1)'(1);
        row1 = {1'b0, cur_row} + (POS_W+1)'(1);

        col_next    = col_reg;
        row_next    = row_reg;
        cstart_next = cstart_reg;
        rstart_next = rstart_reg;
        ch_next     = ch_reg;
        pa_next     = pa_reg;
        pd_next     = pd_reg;
        base_next   = base_reg;

        if (cfg_we)
        begin
            col_next    = '0;
            row_next    = '0;
            cstart_next = '0;
            rstart_next = '0;
            ch_next     = '0;
            pa_next     = '0;
            pd_next     = '0;
            base_next   = '0;
        end
        else if (accept)
        begin
            col_next    = cur_col;
            row_next    = cur_row;
            cstart_next = cur_cstart;
            rstart_next = cur_rstart;
            ch_next     = ch1;
            pa_next     = cur_pa;
            pd_next     = cur_pd;
            base_next   = cur_base;
            if (ch1 >= chans)
            begin
                ch_next = '0;
                if (pa1 >= (PHASE_W+1)'(f_eff))
                begin
                    pa_next     = '0;
                    cstart_next = col1[POS_W-1:0];
                    base_next   = cur_base + ADDR_W'(chans);
                end
                else
                begin
                    pa_next = pa1[PHASE_W-1:0];
                end
                if (col1 >= w_eff)
                begin
                    col_next    = '0;
                    pa_next     = '0;
                    cstart_next = '0;
                    base_next   = '0;
                    if (pd1 >= (PHASE_W+1)'(f_eff))
                    begin
                        pd_next     = '0;
                        rstart_next = row1[POS_W-1:0];
                    end
                    else
                    begin
                        pd_next = pd1[PHASE_W-1:0];
                    end
                    if (row1 >= h_eff)
                    begin
                        row_next    = '0;
                        pd_next     = '0;
                        rstart_next = '0;
                    end
                    else
                    begin
                        row_next = row1[POS_W-1:0];
                    end
                end
                else
                begin
                    col_next = col1[POS_W-1:0];
                end
            end
        end
    end

    // column-sum store: read at accept, add and write back in the next cycle
    logic [SUM_W-1:0] ram_rdata, term, prev, acc;

    ibd_ram #(
        .WIDTH (SUM_W),
        .DEPTH (STORE_DEPTH)
    ) u_sums (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_idx_reg),
        .wdata (acc),
        .re    (accept && active),
        .raddr (idx),
        .rdata (ram_rdata)
    );

    assign term = SUM_W'(s1_x_reg) << s1_sh_reg;
    // take the sum just written when the previous item hit the same entry
    assign prev = s1_fwd_reg ? s2_acc_reg : ram_rdata;
    assign acc  = s1_fresh_reg ? term : term + prev;

    // divide by f*f: reciprocal product, then one correction step; Gaussian mode shifts by GAUSS_SHIFT instead
    localparam int PROD_W = SUM_W + RECIP_W;
    localparam int QD_W   = SUM_W + DIV_W;

    logic [PROD_W-1:0]   prod;
    logic [QD_W-1:0]     qd, rem;
    logic [SUM_W-1:0]    quot, val;
    result_t             res;

    assign prod = PROD_W'(s2_acc_reg) * PROD_W'(recip(f_eff));
    assign qd   = QD_W'(s3_q0_reg) * QD_W'(divisor);
    assign rem  = QD_W'(s3_acc_reg) - qd;
    assign quot = (rem >= QD_W'(divisor)) ? s3_q0_reg + SUM_W'(1) : s3_q0_reg;
    assign val  = gauss ? (s3_acc_reg >> GAUSS_SHIFT) : quot;

    always_comb
    begin
        res.pixel_value   = val[SAMPLE_W-1:0];
        res.channel_index = s3_ch_reg;
        res.frame_last    = s3_last_reg;
    end

    assign push = s3_valid_reg;
    assign pop  = results.valid && results.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= SIZE_W'(1);
            height_reg   <= SIZE_W'(1);
            factor_reg   <= FACTOR_W'(2);
            color_reg    <= 1'b0;
            col_reg      <= '0;
            row_reg      <= '0;
            cstart_reg   <= '0;
            rstart_reg   <= '0;
            ch_reg       <= '0;
            pa_reg       <= '0;
            pd_reg       <= '0;
            base_reg     <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_WIDTH:  width_reg  <= cfg_data[SIZE_W-1:0];
                    CFG_HEIGHT: height_reg <= cfg_data[SIZE_W-1:0];
                    CFG_FACTOR: factor_reg <= cfg_data[FACTOR_W-1:0];
                    CFG_COLOR:  color_reg  <= cfg_data[0];
                    default:    color_reg  <= color_reg;
                endcase
            end
            col_reg    <= col_next;
            row_reg    <= row_next;
            cstart_reg <= cstart_next;
            rstart_reg <= rstart_next;
            ch_reg     <= ch_next;
            pa_reg     <= pa_next;
            pd_reg     <= pd_next;
            base_reg   <= base_next;

            s1_valid_reg <= accept && active;
            s2_valid_reg <= s1_valid_reg && s1_emit_reg;
            s3_valid_reg <= s2_valid_reg;

            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + OUT_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + OUT_PTR_W'(1);
            end
            count_reg <= count_reg + OUT_CNT_W'(push) - OUT_CNT_W'(pop);
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_idx_reg   <= idx;
            s1_x_reg     <= samples.sample;
            s1_sh_reg    <= shift_amt;
            s1_fresh_reg <= fresh;
            s1_emit_reg  <= emit;
            s1_ch_reg    <= cur_ch;
            s1_last_reg  <= last;
            s1_fwd_reg   <= s1_valid_reg && (s1_idx_reg == idx);
        end
        if (s1_valid_reg)
        begin
            s2_acc_reg  <= acc;
            s2_ch_reg   <= s1_ch_reg;
            s2_last_reg <= s1_last_reg;
        end
        if (s2_valid_reg)
        begin
            s3_q0_reg   <= prod[RECIP_SHIFT +: SUM_W];
            s3_acc_reg  <= s2_acc_reg;
            s3_ch_reg   <= s2_ch_reg;
            s3_last_reg <= s2_last_reg;
        end
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= res;
        end
    end

    assign results.valid         = (count_reg != '0);
    assign results.pixel_value   = queue_reg[rd_ptr_reg].pixel_value;
    assign results.channel_index = queue_reg[rd_ptr_reg].channel_index;
    assign results.frame_last    = queue_reg[rd_ptr_reg].frame_last;

endmodule

// File: rtl/core/ibd_checker.sv
module ibd_checker
    import ibd_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [SAMPLE_W-1:0] out_pixel,
    input logic [CHAN_W-1:0]   out_channel,
    input logic                out_last
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable({out_pixel, out_channel, out_last}))
        else $error("stalled result changed or dropped");

    // input backpressure only comes from a waiting result
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no result waiting");

    // channel code never reaches three
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_channel != CHAN_W'(MAX_CHANNELS))
        else $error("channel index out of range");

    // nothing comes out right after reset
    assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result right after reset");

    // a new result needs an earlier valid input item, or follows reset
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid, 4) || !$past(rst_n, 4))
        else $error("result without a source item");

endmodule

bind image_block_downscaler ibd_checker u_ibd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (samples.valid),
    .in_ready    (samples.ready),
    .out_valid   (results.valid),
    .out_ready   (results.ready),
    .out_pixel   (results.pixel_value),
    .out_channel (results.channel_index),
    .out_last    (results.frame_last)
);
